// ===== sv/mbwr_pkg.sv =====
package mbwr_pkg;

    // Input item: one write-single-register request
    typedef struct packed {
        logic [7:0] slave_address;
        logic [7:0] command_value;
    } t_req;

    // Result item: one byte of the request frame
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_rsp;

    // Frame byte positions, transmit order
    localparam logic [2:0] POS_ADDR    = 3'd0;
    localparam logic [2:0] POS_FUNC    = 3'd1;
    localparam logic [2:0] POS_REG_HI  = 3'd2;
    localparam logic [2:0] POS_REG_LO  = 3'd3;
    localparam logic [2:0] POS_VAL_HI  = 3'd4;
    localparam logic [2:0] POS_VAL_LO  = 3'd5;
    localparam logic [2:0] POS_CRC_LO  = 3'd6;
    localparam logic [2:0] POS_CRC_HI  = 3'd7;

    // Fixed frame contents
    localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
    localparam logic [7:0]  REG_ADDR_HI       = 8'h00;
    localparam logic [7:0]  REG_ADDR_LO       = 8'h01;
    localparam logic [7:0]  VALUE_HI          = 8'h00;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;

    // Modbus CRC-16, one byte folded in (reflected, eight shift steps)
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] acc;
        acc = crc ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (acc[0]) begin
                acc = (acc >> 1) ^ CRC_POLY;
            end else begin
                acc = acc >> 1;
            end
        end
        return acc;
    endfunction

endpackage

// ===== sv/modbus_write_register_framer_core.sv =====
// Modbus RTU write-single-register (function 06) request framer. Each accepted
// item (slave address, command value) gives eight result items, one frame byte
// each: address, 0x06, 0x00, 0x01, 0x00, command, CRC low, CRC high, with
// last_byte set on the CRC high byte. One byte leaves per cycle while the output
// is ready, from the byte emitter that walks the frame and folds each body byte
// into the CRC register. A one-item input buffer takes the next
// request while the current frame is going out, so frames follow with no gap.
module modbus_write_register_framer_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  mbwr_pkg::t_req  i_in_item,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output mbwr_pkg::t_rsp  o_out_item
);

    logic            r_in_vld;
    mbwr_pkg::t_req  r_in;
    logic            r_busy;
    logic [2:0]      r_cnt;
    mbwr_pkg::t_req  r_cur;
    logic [15:0]     r_crc;
    logic            r_out_vld;
    mbwr_pkg::t_rsp  r_out;

    logic            advance;
    logic            is_last;
    logic            load;
    logic [7:0]      cur_byte;
    logic [15:0]     n_crc;

    // Emitter handshake
    assign advance    = r_busy && (!r_out_vld || i_out_ready);
    assign is_last    = (r_cnt == mbwr_pkg::POS_CRC_HI);
    assign load       = r_in_vld && (!r_busy || (advance && is_last));
    assign o_in_ready = !r_in_vld || load;

    // Select the frame byte at the current position
    always_comb begin
        case (r_cnt)
            mbwr_pkg::POS_ADDR:   cur_byte = r_cur.slave_address;
            mbwr_pkg::POS_FUNC:   cur_byte = mbwr_pkg::FUNC_WRITE_SINGLE;
            mbwr_pkg::POS_REG_HI: cur_byte = mbwr_pkg::REG_ADDR_HI;
            mbwr_pkg::POS_REG_LO: cur_byte = mbwr_pkg::REG_ADDR_LO;
            mbwr_pkg::POS_VAL_HI: cur_byte = mbwr_pkg::VALUE_HI;
            mbwr_pkg::POS_VAL_LO: cur_byte = r_cur.command_value;
            mbwr_pkg::POS_CRC_LO: cur_byte = r_crc[7:0];
            mbwr_pkg::POS_CRC_HI: cur_byte = r_crc[15:8];
            default:              cur_byte = 8'h00;
        endcase
    end

    // CRC covers the six body bytes only
    assign n_crc = mbwr_pkg::crc_byte(r_crc, cur_byte);

    // Input buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_vld <= 1'b1;
        end else if (load) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
    end

    // Byte emitter control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= mbwr_pkg::POS_ADDR;
        end else if (load) begin
            r_busy <= 1'b1;
            r_cnt  <= mbwr_pkg::POS_ADDR;
        end else if (advance) begin
            r_busy <= !is_last;
            r_cnt  <= r_cnt + 3'd1;
        end
    end

    // Emitter payload and running CRC
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur <= r_in;
            r_crc <= mbwr_pkg::CRC_INIT;
        end else if (advance && (r_cnt < mbwr_pkg::POS_CRC_LO)) begin
            r_crc <= n_crc;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.frame_byte <= cur_byte;
            r_out.last_byte  <= is_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule
